>>> rtl/mhsd_pkg.sv
// shared types and constants for the min-heap descending sorter
`default_nettype none
package mhsd_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD,
    ST_SD_B,
    ST_SD_C,
    ST_SD_D,
    ST_SD_E,
    ST_SD_F,
    ST_EXTRACT,
    ST_SW_A,
    ST_SW_B,
    ST_SW_C,
    ST_SW_D,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

endpackage
`default_nettype wire

>>> rtl/min_heap_sort_descending_top.sv
// top level: batch heap sort of signed words, emitted largest first
// loading: one input word per cycle; after the last word the sort is paced by one
//   store read port and one shared signed comparator
// output: each result word is read from the store, then handed to the output
//   register once it is free; after the last result word, loading resumes
// reset: element count, overflow flag, sequencer and output valid clear at once;
//   the store itself is not cleared, only words of the current batch are read
`default_nettype none
module min_heap_sort_descending_top #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input word stream
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [mhsd_pkg::DATA_W-1:0]        s_axis_tdata_i,  // [31:0] value
  input  wire logic                               s_axis_tlast_i,  // last_in
  // result word stream
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  output logic [mhsd_pkg::DATA_W-1:0]             m_axis_tdata_o,  // [31:0] sorted_value
  output logic                                    m_axis_tlast_o,  // last_out
  output logic                                    m_axis_tuser_o   // [0] dropped
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;  // store index
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);                   // count width
  localparam int unsigned XW = AW + 2;                                   // child index

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  mhsd_pkg::state_e state_q, state_d;

  // batch bookkeeping
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          build_q, build_d;   // 1 while building heap, 0 while extracting
  logic [CW-1:0] k_q, k_d;           // outer loop counter
  logic [CW-1:0] size_q, size_d;     // current heap size

  // sift-down working registers
  logic [AW-1:0] node_q, node_d;
  logic [AW-1:0] least_q, least_d;
  logic signed [mhsd_pkg::DATA_W-1:0] cur_q, cur_d;    // value travelling down
  logic signed [mhsd_pkg::DATA_W-1:0] lval_q, lval_d;  // smallest seen this level

  logic [AW-1:0] idx_q, idx_d;       // emit index

  // output register
  logic                        m_valid_q, m_valid_d;
  logic [mhsd_pkg::DATA_W-1:0] m_data_q, m_data_d;
  logic                        m_last_q, m_last_d;
  logic                        m_drop_q, m_drop_d;

  // store port
  logic                               we;
  logic [AW-1:0]                      waddr, raddr;
  logic signed [mhsd_pkg::DATA_W-1:0] wdata, rdata;

  mhsd_ram #(
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // child indices and bounds checks
  logic [XW-1:0] size_x, lc_x, rc_x, lcn_x;
  logic          lc_ok, rc_ok, lcn_ok;
  logic          cmp_lt;             // shared signed comparator
  logic [CW-1:0] km1;
  logic [CW-1:0] load_cnt;
  logic          in_acc, out_free;

  assign size_x = XW'(size_q);
  assign lc_x   = {1'b0, node_q, 1'b1};
  assign rc_x   = lc_x + XW'(1);
  assign lcn_x  = {1'b0, least_q, 1'b1};
  assign lc_ok  = lc_x < size_x;
  assign rc_ok  = rc_x < size_x;
  assign lcn_ok = lcn_x < size_x;
  assign cmp_lt = rdata < lval_q;
  assign km1    = k_q - CW'(1);

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign load_cnt = (count_q < MAX_CNT) ? count_q + CW'(1) : count_q;

  assign s_axis_tready_o = (state_q == mhsd_pkg::ST_LOAD);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mhsd_pkg::ST_LOAD;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      build_q   <= 1'b0;
      k_q       <= '0;
      size_q    <= '0;
      node_q    <= '0;
      least_q   <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      build_q   <= build_d;
      k_q       <= k_d;
      size_q    <= size_d;
      node_q    <= node_d;
      least_q   <= least_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    lval_q   <= lval_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_drop_q <= m_drop_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    build_d   = build_q;
    k_d       = k_q;
    size_d    = size_q;
    node_d    = node_q;
    least_d   = least_q;
    cur_d     = cur_q;
    lval_d    = lval_q;
    idx_d     = idx_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    m_drop_d  = m_drop_q;
    we        = 1'b0;
    waddr     = count_q[AW-1:0];
    wdata     = s_axis_tdata_i;
    raddr     = idx_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      mhsd_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (count_q < MAX_CNT) begin
            we = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          count_d = load_cnt;
          if (s_axis_tlast_i) begin
            k_d     = load_cnt >> 1;
            size_d  = load_cnt;
            build_d = 1'b1;
            state_d = mhsd_pkg::ST_BUILD;
          end
        end
      end

      // heapify: sift down from the middle index back to the root
      mhsd_pkg::ST_BUILD: begin
        if (k_q == '0) begin
          k_d     = count_q;
          build_d = 1'b0;
          state_d = mhsd_pkg::ST_EXTRACT;
        end else begin
          k_d     = km1;
          node_d  = km1[AW-1:0];
          size_d  = count_q;
          raddr   = km1[AW-1:0];
          state_d = mhsd_pkg::ST_SD_B;
        end
      end

      // node value arrives
      mhsd_pkg::ST_SD_B: begin
        cur_d   = rdata;
        lval_d  = rdata;
        least_d = node_q;
        if (lc_ok) begin
          raddr   = lc_x[AW-1:0];
          state_d = mhsd_pkg::ST_SD_C;
        end else begin
          state_d = build_q ? mhsd_pkg::ST_BUILD : mhsd_pkg::ST_EXTRACT;
        end
      end

      // left child arrives
      mhsd_pkg::ST_SD_C: begin
        if (cmp_lt) begin
          lval_d  = rdata;
          least_d = lc_x[AW-1:0];
        end
        if (rc_ok) begin
          raddr   = rc_x[AW-1:0];
          state_d = mhsd_pkg::ST_SD_D;
        end else begin
          state_d = mhsd_pkg::ST_SD_E;
        end
      end

      // right child arrives
      mhsd_pkg::ST_SD_D: begin
        if (cmp_lt) begin
          lval_d  = rdata;
          least_d = rc_x[AW-1:0];
        end
        state_d = mhsd_pkg::ST_SD_E;
      end

      // heap property holds, or move the smaller child up
      mhsd_pkg::ST_SD_E: begin
        if (least_q == node_q) begin
          state_d = build_q ? mhsd_pkg::ST_BUILD : mhsd_pkg::ST_EXTRACT;
        end else begin
          we      = 1'b1;
          waddr   = node_q;
          wdata   = lval_q;
          state_d = mhsd_pkg::ST_SD_F;
        end
      end

      // drop the travelling value one level, start reading the next left child
      mhsd_pkg::ST_SD_F: begin
        we      = 1'b1;
        waddr   = least_q;
        wdata   = cur_q;
        node_d  = least_q;
        lval_d  = cur_q;
        if (lcn_ok) begin
          raddr   = lcn_x[AW-1:0];
          state_d = mhsd_pkg::ST_SD_C;
        end else begin
          state_d = build_q ? mhsd_pkg::ST_BUILD : mhsd_pkg::ST_EXTRACT;
        end
      end

      // move the root minimum to the end of the shrinking heap
      mhsd_pkg::ST_EXTRACT: begin
        if (k_q <= CW'(1)) begin
          idx_d   = '0;
          state_d = mhsd_pkg::ST_EMIT_RD;
        end else begin
          k_d     = km1;
          size_d  = km1;
          node_d  = '0;
          state_d = mhsd_pkg::ST_SW_A;
        end
      end

      mhsd_pkg::ST_SW_A: begin
        raddr   = '0;
        state_d = mhsd_pkg::ST_SW_B;
      end

      mhsd_pkg::ST_SW_B: begin
        cur_d   = rdata;
        raddr   = size_q[AW-1:0];
        state_d = mhsd_pkg::ST_SW_C;
      end

      mhsd_pkg::ST_SW_C: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = rdata;
        state_d = mhsd_pkg::ST_SW_D;
      end

      // finish the swap and issue the root read for the sift
      mhsd_pkg::ST_SW_D: begin
        we      = 1'b1;
        waddr   = size_q[AW-1:0];
        wdata   = cur_q;
        raddr   = '0;
        state_d = mhsd_pkg::ST_SD_B;
      end

      mhsd_pkg::ST_EMIT_RD: begin
        state_d = mhsd_pkg::ST_EMIT_WR;
      end

      // hand one word to the output register when it is free
      mhsd_pkg::ST_EMIT_WR: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = rdata;
          m_drop_d  = ovf_q;
          m_last_d  = (CW'(idx_q) + CW'(1)) == count_q;
          if ((CW'(idx_q) + CW'(1)) == count_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = mhsd_pkg::ST_LOAD;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = mhsd_pkg::ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = mhsd_pkg::ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/mhsd_ram.sv
// single write port, single registered read port element store
`default_nettype none
module mhsd_ram #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [$clog2(DEPTH)-1:0]             waddr_i,
  input  wire logic signed [mhsd_pkg::DATA_W-1:0]   wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]             raddr_i,
  output logic signed [mhsd_pkg::DATA_W-1:0]        rdata_o
);

  logic signed [mhsd_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire
